>>> rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon ray-crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Field positions inside s_tdata
    localparam int IDX_LSB = 0;
    localparam int X_LSB   = IDX_LSB + IDX_W;
    localparam int Y_LSB   = X_LSB + COORD_W;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } edge_status_t;

endpackage

>>> rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-crossing test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests. s_tuser selects the kind: load writes one
//   vertex into the slot given by vertex_index, query tests a point against
//   the first vertex_count stored vertices. A load gives no result; a query
//   gives one result on the m_ channel (m_tdata bit 0 = inside).
//   cfg_ channel writes vertex_count (values above MAX_VERTICES saturate).
//   Write it only while no query is in flight.
// Timing:
//   A query walks the vertex memory read port one vertex per cycle
//   (n + 1 reads for n vertices in use, the last vertex first), and each
//   edge then passes through the shared edge unit before m_tvalid. A count
//   of zero answers outside. s_tready is low while a query walks or drains.
// Reset clears the sequencer, the count and the output valid; the vertex
// memory is not cleared and must be loaded before use. When the receiver
// stalls, the result holds in the output register and the next request can
// be taken; a following query finishes its walk and waits to deliver.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // tdata: vertex_index[5:0], coord_x[21:6], coord_y[37:22], zero pad
    input  logic [pip_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: op
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,

    // tdata: inside_res[0], zero pad
    output logic [pip_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,

    input  logic [pip_pkg::CNT_W-1:0]       cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int WW = (CW > pip_pkg::CNT_W) ? CW : pip_pkg::CNT_W;

    pip_pkg::state_t        state_reg, state_next;
    logic [pip_pkg::CNT_W-1:0] cnt_reg;
    logic [CW-1:0]          n_reg;
    logic [CW-1:0]          k_reg;
    logic [CW-1:0]          n_sat;
    pip_pkg::point_t        pt_reg;
    pip_pkg::point_t        prev_reg;
    pip_pkg::point_t        rd_data_reg;
    logic                   rd_valid_reg;
    logic                   rd_first_reg;
    logic                   inside_reg;
    logic                   m_tvalid_reg;
    logic                   m_inside_reg;

    pip_pkg::point_t        mem [MAX_VERTICES];
    pip_pkg::point_t        in_pt;
    logic [pip_pkg::IDX_W-1:0] in_idx;
    logic                   s_acc;
    logic                   is_query;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic                   rd_issue;
    logic                   done;
    logic                   edge_valid;
    pip_pkg::edge_status_t  edge_st;

    // Unpack request
    always_comb begin
        in_idx   = s_tdata[pip_pkg::IDX_LSB +: pip_pkg::IDX_W];
        in_pt.x  = s_tdata[pip_pkg::X_LSB +: pip_pkg::COORD_W];
        in_pt.y  = s_tdata[pip_pkg::Y_LSB +: pip_pkg::COORD_W];
        s_acc    = s_tvalid && s_tready;
        is_query = (s_tuser == pip_pkg::OP_QUERY);
        if (WW'(cnt_reg) > WW'(MAX_VERTICES)) begin
            n_sat = CW'(MAX_VERTICES);
        end else begin
            n_sat = CW'(cnt_reg);
        end
        wr_en   = s_acc && !is_query && (32'(in_idx) < MAX_VERTICES);
        wr_addr = AW'(in_idx);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pip_pkg::ST_IDLE: begin
                if (s_acc && is_query) begin
                    state_next = (n_sat == '0) ? pip_pkg::ST_DRAIN : pip_pkg::ST_WALK;
                end
            end
            pip_pkg::ST_WALK: begin
                if (k_reg == n_reg) begin
                    state_next = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN: begin
                if (done) begin
                    state_next = pip_pkg::ST_IDLE;
                end
            end
            default: state_next = pip_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            pip_pkg::ST_IDLE:  s_tready = 1'b1;
            pip_pkg::ST_WALK:  rd_issue = 1'b1;
            pip_pkg::ST_DRAIN: done = !rd_valid_reg && !edge_st.busy &&
                                      (!m_tvalid_reg || m_tready);
            default: ;
        endcase
        // first read fetches the closing vertex, then slots 0 upward
        if (k_reg == '0) begin
            rd_addr = AW'(n_reg - CW'(1));
        end else begin
            rd_addr = AW'(k_reg - CW'(1));
        end
        edge_valid = rd_valid_reg && !rd_first_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pip_pkg::ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_issue;
            if (cfg_valid && cfg_ready) begin
                cnt_reg <= cfg_data;
            end
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && is_query) begin
            pt_reg     <= in_pt;
            n_reg      <= n_sat;
            k_reg      <= '0;
            inside_reg <= 1'b0;
        end else begin
            if (rd_issue) begin
                k_reg <= k_reg + CW'(1);
            end
            if (edge_st.hit) begin
                inside_reg <= !inside_reg;
            end
        end
        rd_first_reg <= (k_reg == '0);
        if (rd_valid_reg) begin
            prev_reg <= rd_data_reg;
        end
        if (done) begin
            m_inside_reg <= inside_reg;
        end
    end

    // Vertex memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_pt;
        end
        rd_data_reg <= mem[rd_addr];
    end

    pip_edge_unit u_edge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .edge_valid (edge_valid),
        .vtx_i      (rd_data_reg),
        .vtx_j      (prev_reg),
        .pt         (pt_reg),
        .status     (edge_st)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(pip_pkg::M_TDATA_W-1){1'b0}}, m_inside_reg};

endmodule

>>> rtl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge evaluator: one polygon edge per cycle, two pipeline steps.
// Step one forms the straddle test and both cross products, step two
// compares them with the sense given by the sign of dy.
// ----------------------------------------------------------------------------
module pip_edge_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   edge_valid,
    input  pip_pkg::point_t        vtx_i,
    input  pip_pkg::point_t        vtx_j,
    input  pip_pkg::point_t        pt,
    output pip_pkg::edge_status_t  status
);

    logic signed [pip_pkg::DIFF_W-1:0] dy;
    logic signed [pip_pkg::DIFF_W-1:0] dx_p;
    logic signed [pip_pkg::DIFF_W-1:0] dx_e;
    logic signed [pip_pkg::DIFF_W-1:0] dy_p;
    logic                              straddle;

    logic                              s1_valid_reg;
    logic                              s1_straddle_reg;
    logic                              s1_dy_pos_reg;
    logic signed [pip_pkg::PROD_W-1:0] s1_lhs_reg;
    logic signed [pip_pkg::PROD_W-1:0] s1_rhs_reg;
    logic                              cross_ok;

    always_comb begin
        dy   = pip_pkg::DIFF_W'(vtx_j.y) - pip_pkg::DIFF_W'(vtx_i.y);
        dx_p = pip_pkg::DIFF_W'(pt.x)    - pip_pkg::DIFF_W'(vtx_i.x);
        dx_e = pip_pkg::DIFF_W'(vtx_j.x) - pip_pkg::DIFF_W'(vtx_i.x);
        dy_p = pip_pkg::DIFF_W'(pt.y)    - pip_pkg::DIFF_W'(vtx_i.y);
        // lower end inclusive, upper end exclusive
        straddle = ((vtx_i.y <= pt.y) && (pt.y < vtx_j.y)) ||
                   ((vtx_j.y <= pt.y) && (pt.y < vtx_i.y));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= edge_valid;
        end
    end

    always_ff @(posedge aclk) begin
        s1_straddle_reg <= straddle;
        s1_dy_pos_reg   <= (dy > 0);
        s1_lhs_reg      <= dx_p * dy;
        s1_rhs_reg      <= dx_e * dy_p;
    end

    always_comb begin
        if (s1_dy_pos_reg) begin
            cross_ok = (s1_lhs_reg < s1_rhs_reg);
        end else begin
            cross_ok = (s1_lhs_reg > s1_rhs_reg);
        end
        status.busy = s1_valid_reg;
        status.hit  = s1_valid_reg && s1_straddle_reg && cross_ok;
    end

endmodule

>>> tb/sv/point_in_polygon_test_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_checker
// Watches the load/query, result and count channels of the point-in-polygon
// block. It keeps its own vertex store and vertex count, works out the
// even-odd answer for every accepted query and checks each result against the
// oldest answer still waiting.
// ----------------------------------------------------------------------------
module point_in_polygon_test_checker #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // tdata: vertex_index[5:0], coord_x[21:6], coord_y[37:22], zero pad
    input  logic [pip_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: op
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,

    // tdata: inside_res[0], zero pad
    input  logic [pip_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,

    input  logic [pip_pkg::CNT_W-1:0]       cfg_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,

    output int                              err_count,
    output int                              pending,
    output int                              query_count,
    output int                              result_count
);

    typedef logic signed [pip_pkg::COORD_W-1:0] coord_t;

    coord_t                    vert_x [MAX_VERTICES];
    coord_t                    vert_y [MAX_VERTICES];
    logic [pip_pkg::CNT_W-1:0] vertex_count_q;
    bit                        inside_expected_q [$];

    // Exact crossing test: compare cross products instead of dividing,
    // flipping the sense when the edge runs downward.
    function automatic bit ray_crosses_edge(input coord_t xi, input coord_t yi,
                                            input coord_t xj, input coord_t yj,
                                            input coord_t px, input coord_t py);
        bit     straddle;
        longint dy;
        longint lhs;
        longint rhs;
        straddle = ((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi));
        dy  = longint'(yj) - longint'(yi);
        lhs = (longint'(px) - longint'(xi)) * dy;
        rhs = (longint'(xj) - longint'(xi)) * (longint'(py) - longint'(yi));
        if (!straddle)
            return 1'b0;
        if (dy > 0)
            return lhs < rhs;
        return lhs > rhs;
    endfunction

    function automatic bit point_inside(input coord_t px, input coord_t py);
        int n;
        int j;
        bit odd;
        n = (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_q);
        odd = 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            if (ray_crosses_edge(vert_x[i], vert_y[i], vert_x[j], vert_y[j], px, py))
                odd = !odd;
            j = i;
        end
        return odd;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    always @(posedge aclk) begin
        logic [pip_pkg::IDX_W-1:0] slot;
        coord_t                    px;
        coord_t                    py;
        bit                        want;
        if (!aresetn) begin
            inside_expected_q.delete();
            vertex_count_q = '0;
            err_count      = 0;
            query_count    = 0;
            result_count   = 0;
        end else begin
            // results first: a result never belongs to a query taken this edge
            if (m_tvalid && m_tready) begin
                result_count++;
                if (inside_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %b with no query waiting",
                                              m_tdata[0]));
                end else begin
                    want = inside_expected_q.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch($sformatf("result %0d: inside_res %b, want %0b",
                                                  result_count, m_tdata[0], want));
                end
            end
            if (cfg_valid && cfg_ready)
                vertex_count_q = cfg_data;
            if (s_tvalid && s_tready) begin
                slot = s_tdata[pip_pkg::IDX_LSB +: pip_pkg::IDX_W];
                px   = s_tdata[pip_pkg::X_LSB +: pip_pkg::COORD_W];
                py   = s_tdata[pip_pkg::Y_LSB +: pip_pkg::COORD_W];
                if (s_tuser == pip_pkg::OP_QUERY) begin
                    inside_expected_q = {inside_expected_q, point_inside(px, py)};
                    query_count++;
                end else if (slot < MAX_VERTICES) begin
                    vert_x[slot] = px;
                    vert_y[slot] = py;
                end
            end
        end
        pending = inside_expected_q.size();
    end

endmodule

>>> tb/sv/point_in_polygon_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb
// Drives vertex loads, point queries and vertex count writes into the
// point-in-polygon block with bursty requests and a stalling receiver; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_LIMIT    = 3000;
    localparam int ITEM_TARGET   = 1400;
    localparam int NUM_SLOTS     = 64;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic [pip_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [pip_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [pip_pkg::CNT_W-1:0]       cfg_data  = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;

    int err_count;
    int pending;
    int query_count;
    int result_count;

    int burst_left  = 0;
    int item_total  = 0;
    int load_total  = 0;
    int cfg_total   = 0;
    int idle_cycles = 0;
    int vx_sent [NUM_SLOTS];
    int vy_sent [NUM_SLOTS];

    // receiver stall pattern
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold      = 0;
    int rx_tick      = 0;

    always #(CLK_HALF) aclk = ~aclk;

    point_in_polygon_test u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    point_in_polygon_test_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_data     (cfg_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .err_count    (err_count),
        .pending      (pending),
        .query_count  (query_count),
        .result_count (result_count)
    );

    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_tready <= (rx_tick % 4 == 0);
            end
            default: begin
                // long low runs broken by short ready windows
                if (rx_hold == 0) begin
                    m_tready <= ~m_tready;
                    rx_hold  <= m_tready ? $urandom_range(5, 40) : $urandom_range(1, 3);
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                     || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int clamp16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int spread(input int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    task automatic send_req(input pip_pkg::op_t kind, input int slot,
                            input int x, input int y);
        int                            gap;
        logic [pip_pkg::S_TDATA_W-1:0] word;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        word = '0;
        word[pip_pkg::IDX_LSB +: pip_pkg::IDX_W] = pip_pkg::IDX_W'(slot);
        word[pip_pkg::X_LSB +: pip_pkg::COORD_W] = x[pip_pkg::COORD_W-1:0];
        word[pip_pkg::Y_LSB +: pip_pkg::COORD_W] = y[pip_pkg::COORD_W-1:0];
        s_tuser  <= kind;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        item_total++;
        if (kind == pip_pkg::OP_LOAD) begin
            load_total++;
            vx_sent[slot] = clamp16(x);
            vy_sent[slot] = clamp16(y);
        end
    endtask

    task automatic query_point(input int x, input int y);
        send_req(pip_pkg::OP_QUERY, int'($urandom_range(0, NUM_SLOTS - 1)), x, y);
    endtask

    // hold requests until every result is back, then let the block go quiet
    task automatic wait_settled();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(input int value);
        wait_settled();
        cfg_data  <= value[pip_pkg::CNT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_total++;
    endtask

    initial begin
        int phase;
        int n;
        int nv;
        int scale;
        int cx;
        int cy;
        int r;
        int k;
        int x;
        int y;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty polygon answers outside
        write_count(0);
        query_point(5, 5);

        // axis-aligned square
        send_req(pip_pkg::OP_LOAD, 0, -100, -100);
        send_req(pip_pkg::OP_LOAD, 1, 100, -100);
        send_req(pip_pkg::OP_LOAD, 2, 100, 100);
        send_req(pip_pkg::OP_LOAD, 3, -100, 100);
        write_count(4);
        query_point(0, 0);
        query_point(200, 0);
        query_point(-100, -100);   // on a vertex
        query_point(100, 0);       // on the right edge crossing
        query_point(-100, 0);      // on the left edge crossing
        query_point(0, 100);       // on the top horizontal edge
        query_point(0, -100);      // on the bottom horizontal edge
        query_point(-32768, 0);
        query_point(32767, 0);

        // full-range triangle, plus the highest slot
        send_req(pip_pkg::OP_LOAD, 0, -32768, -32768);
        send_req(pip_pkg::OP_LOAD, 1, 32767, -32768);
        send_req(pip_pkg::OP_LOAD, 2, 0, 32767);
        send_req(pip_pkg::OP_LOAD, NUM_SLOTS - 1, 32767, 32767);
        write_count(3);
        query_point(0, 0);
        query_point(-32768, -32768);
        query_point(32767, 32767);
        query_point(0, 32766);
        query_point(-1, -32768);

        phase = 0;
        while (item_total < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (phase == 3)
                n = NUM_SLOTS;
            else if (phase == 7)
                n = 127;
            else if (r < 5)
                n = 0;
            else if (r < 12)
                n = $urandom_range(1, 2);
            else if (r < 85)
                n = $urandom_range(3, 12);
            else if (r < 95)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(NUM_SLOTS, 127);
            nv = (n > NUM_SLOTS) ? NUM_SLOTS : n;

            case ($urandom_range(0, 3))
                0:       scale = 20;
                1:       scale = 300;
                2:       scale = 5000;
                default: scale = 32767;
            endcase
            cx = spread(32767 - scale);
            cy = spread(32767 - scale);

            // every slot in use is loaded before the count covers it
            for (k = 0; k < nv; k++)
                send_req(pip_pkg::OP_LOAD, k, clamp16(cx + spread(scale)),
                         clamp16(cy + spread(scale)));
            write_count(n);

            repeat ($urandom_range(5, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_req(pip_pkg::OP_LOAD, int'($urandom_range(0, NUM_SLOTS - 1)),
                             clamp16(cx + spread(scale)), clamp16(cy + spread(scale)));
                end else begin
                    if (r < 50 || nv == 0) begin
                        x = clamp16(cx + spread(scale + scale / 4));
                        y = clamp16(cy + spread(scale + scale / 4));
                    end else if (r < 70) begin
                        k = $urandom_range(0, nv - 1);
                        x = clamp16(vx_sent[k] + spread(1));
                        y = vy_sent[k];
                    end else if (r < 85) begin
                        k = $urandom_range(0, nv - 1);
                        x = clamp16(cx + spread(scale + scale / 4));
                        y = vy_sent[k];
                    end else begin
                        x = int'($urandom_range(0, 65535)) - 32768;
                        y = int'($urandom_range(0, 65535)) - 32768;
                    end
                    query_point(x, y);
                end
                if ($urandom_range(0, 39) == 0)
                    wait_settled();
            end
            phase++;
        end

        wait_settled();
        $display("summary: %0d requests (%0d loads, %0d queries), %0d results, %0d count writes",
                 item_total, load_total, query_count, result_count, cfg_total);
        $display("summary: polygons of 0 to 64 vertices, saturated counts, full-range points");
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", err_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
